[rtl/core/ecc_point_scalar_multiply_assert.svh]
// Assertion macros for the elliptic curve point multiplier.
// Used by the top level only; needs nothing else.
`ifndef ECC_POINT_SCALAR_MULTIPLY_ASSERT_SVH
`define ECC_POINT_SCALAR_MULTIPLY_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ECCPSM_ASSERT_NOW(NAME, CLK, RSTN, ANT, CON, MSG) \
  NAME: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |-> (CON)) \
    else $error(MSG);

// Consequent must hold in the cycle after the antecedent.
`define ECCPSM_ASSERT_NEXT(NAME, CLK, RSTN, ANT, CON, MSG) \
  NAME: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |=> (CON)) \
    else $error(MSG);

`endif

[rtl/core/eccpsm_pkg.sv]
// Shared types and constants of the elliptic curve point multiplier.
// Used by the interfaces, the field arithmetic unit and the top level.
`default_nettype none
package eccpsm_pkg;

  localparam int unsigned DEFAULT_FIELD_WIDTH = 64;
  localparam int unsigned APB_DATA_W = 64;
  localparam int unsigned PADDR_W = 4;
  localparam logic [63:0] PRIME_RESET = 64'd127;
  localparam logic [63:0] CURVE_A_RESET = 64'd1;
  localparam logic REG_PRIME = 1'b0;
  localparam logic REG_CURVE_A = 1'b1;

  typedef enum logic [1:0] {
    FAU_ADD,
    FAU_SUB,
    FAU_MUL,
    FAU_DIV
  } fau_op_e;

  typedef struct packed {
    logic    start;
    fau_op_e op;
  } fau_req_t;

endpackage
`default_nettype wire

[rtl/core/eccpsm_ifs.sv]
// Request channels of the point multiplier: base point in, result point out.
// Depends on eccpsm_pkg for the default field width.
`default_nettype none
interface eccpsm_in_if #(
  parameter int unsigned W = eccpsm_pkg::DEFAULT_FIELD_WIDTH
);
  logic         valid;
  logic         ready;
  logic [W-1:0] point_x;
  logic [W-1:0] point_y;
  logic [W-1:0] scalar;
  modport source (output valid, point_x, point_y, scalar, input ready);
  modport sink (input valid, point_x, point_y, scalar, output ready);
endinterface

interface eccpsm_out_if #(
  parameter int unsigned W = eccpsm_pkg::DEFAULT_FIELD_WIDTH
);
  logic         valid;
  logic         ready;
  logic [W-1:0] result_x;
  logic [W-1:0] result_y;
  modport source (output valid, result_x, result_y, input ready);
  modport sink (input valid, result_x, result_y, output ready);
endinterface
`default_nettype wire

[rtl/core/ecc_point_scalar_multiply.sv]
// Each request first reduces the operands modulo the prime, then runs point additions,
// each inverse taking Euclid steps; up to 2(W-1) additions per request.
// One request is in work at a time; the bit-serial multiply and divide unit sets the pace.
// A finished result waits in the output register while the next request is taken.
// Reset clears the control state and loads the modulus with 127 and the coefficient with 1.
`default_nettype none
`include "ecc_point_scalar_multiply_assert.svh"
module ecc_point_scalar_multiply #(
  parameter int unsigned FIELD_WIDTH = eccpsm_pkg::DEFAULT_FIELD_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [eccpsm_pkg::PADDR_W-1:0]    paddr,
  input  logic [eccpsm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [eccpsm_pkg::APB_DATA_W-1:0] prdata,
  output logic                              pready,
  eccpsm_in_if.sink                         point_i,
  eccpsm_out_if.source                      result_o
);
  import eccpsm_pkg::*;

  localparam int unsigned W = FIELD_WIDTH;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RX, ST_RY, ST_RA, ST_LOOP, ST_SHIFT, ST_PDX, ST_PDY, ST_PCHK,
    ST_PG, ST_TSQ, ST_T2, ST_T3, ST_TA, ST_IINIT, ST_ITEST, ST_IDIV, ST_IQR,
    ST_IMUL, ST_ISUB, ST_SLOPE, ST_X1, ST_X2, ST_X3, ST_Y1, ST_Y2, ST_Y3,
    ST_WB, ST_OUT
  } state_e;

  state_e       state_q;
  logic         pend_q, dst_q, ovalid_q;
  logic [W-1:0] pr_q, ca_q, ar_q;
  logic [W-1:0] dx_q, dy_q, ax_q, ay_q, ux_q, uy_q;
  logic [W-1:0] e_q, f_q, g_q, s_q, q_q, r0_q, r1_q, t0_q, t1_q, k_q;
  logic [W-1:0] rx_q, ry_q;

  fau_req_t     fau_req;
  logic         op_state, fau_done;
  logic [W-1:0] op_a, op_b, fau_y, fau_rem;

  always_comb begin
    op_state    = 1'b1;
    fau_req.op  = FAU_ADD;
    op_a        = '0;
    op_b        = '0;
    case (state_q)
      ST_RX:    begin fau_req.op = FAU_DIV; op_a = dx_q; op_b = pr_q; end
      ST_RY:    begin fau_req.op = FAU_DIV; op_a = dy_q; op_b = pr_q; end
      ST_RA:    begin fau_req.op = FAU_DIV; op_a = ca_q; op_b = pr_q; end
      ST_PDX:   begin fau_req.op = FAU_SUB; op_a = ux_q; op_b = dx_q; end
      ST_PDY:   begin fau_req.op = FAU_SUB; op_a = uy_q; op_b = dy_q; end
      ST_PG:    begin fau_req.op = FAU_ADD; op_a = dy_q; op_b = uy_q; end
      ST_TSQ:   begin fau_req.op = FAU_MUL; op_a = dx_q; op_b = dx_q; end
      ST_T2:    begin fau_req.op = FAU_ADD; op_a = s_q;  op_b = s_q;  end
      ST_T3:    begin fau_req.op = FAU_ADD; op_a = f_q;  op_b = s_q;  end
      ST_TA:    begin fau_req.op = FAU_ADD; op_a = f_q;  op_b = ar_q; end
      ST_IDIV:  begin fau_req.op = FAU_DIV; op_a = r0_q; op_b = r1_q; end
      ST_IMUL:  begin fau_req.op = FAU_MUL; op_a = q_q;  op_b = t1_q; end
      ST_ISUB:  begin fau_req.op = FAU_SUB; op_a = t0_q; op_b = q_q;  end
      ST_SLOPE: begin fau_req.op = FAU_MUL; op_a = f_q;  op_b = t0_q; end
      ST_X1:    begin fau_req.op = FAU_MUL; op_a = s_q;  op_b = s_q;  end
      ST_X2:    begin fau_req.op = FAU_SUB; op_a = g_q;  op_b = dx_q; end
      ST_X3:    begin fau_req.op = FAU_SUB; op_a = g_q;  op_b = ux_q; end
      ST_Y1:    begin fau_req.op = FAU_SUB; op_a = dx_q; op_b = e_q;  end
      ST_Y2:    begin fau_req.op = FAU_MUL; op_a = g_q;  op_b = s_q;  end
      ST_Y3:    begin fau_req.op = FAU_SUB; op_a = g_q;  op_b = dy_q; end
      default:  begin op_state = 1'b0; end
    endcase
    fau_req.start = op_state && !pend_q;
  end

  eccpsm_fau #(
    .W (W)
  ) u_fau (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fau_req),
    .a_i    (op_a),
    .b_i    (op_b),
    .p_i    (pr_q),
    .done_o (fau_done),
    .y_o    (fau_y),
    .rem_o  (fau_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_q <= W'(PRIME_RESET);
      ca_q <= W'(CURVE_A_RESET);
    end else if (psel && penable && pwrite) begin
      if (paddr[3] == REG_PRIME) begin
        pr_q <= pwdata[W-1:0];
      end else begin
        ca_q <= pwdata[W-1:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_PRIME) ? APB_DATA_W'(pr_q) : APB_DATA_W'(ca_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pend_q   <= 1'b0;
      dst_q    <= 1'b0;
      ovalid_q <= 1'b0;
      ar_q <= '0; dx_q <= '0; dy_q <= '0; ax_q <= '0; ay_q <= '0;
      ux_q <= '0; uy_q <= '0; e_q <= '0; f_q <= '0; g_q <= '0; s_q <= '0;
      q_q <= '0; r0_q <= '0; r1_q <= '0; t0_q <= '0; t1_q <= '0; k_q <= '0;
      rx_q <= '0; ry_q <= '0;
    end else begin
      if (ovalid_q && result_o.ready && (state_q != ST_OUT)) begin
        ovalid_q <= 1'b0;
      end
      if (op_state) begin
        if (!pend_q) begin
          pend_q <= 1'b1;
        end else if (fau_done) begin
          pend_q <= 1'b0;
        end
      end
      case (state_q)
        ST_IDLE: begin
          if (point_i.valid) begin
            dx_q <= point_i.point_x;
            dy_q <= point_i.point_y;
            k_q  <= point_i.scalar;
            if (pr_q == '0) begin
              ax_q    <= '0;
              ay_q    <= '0;
              state_q <= ST_OUT;
            end else begin
              state_q <= ST_RX;
            end
          end
        end
        ST_LOOP: begin
          if (k_q == '0) begin
            state_q <= ST_OUT;
          end else if (k_q[0]) begin
            ux_q    <= ax_q;
            uy_q    <= ay_q;
            dst_q   <= 1'b1;
            state_q <= ST_PDX;
          end else begin
            state_q <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          k_q <= k_q >> 1;
          if ((k_q >> 1) == '0) begin
            state_q <= ST_OUT;
          end else begin
            ux_q    <= dx_q;
            uy_q    <= dy_q;
            dst_q   <= 1'b0;
            state_q <= ST_PDX;
          end
        end
        ST_PCHK: begin
          if (e_q != '0) begin
            g_q     <= e_q;
            state_q <= ST_IINIT;
          end else if (f_q == '0) begin
            state_q <= ST_PG;
          end else begin
            state_q <= dst_q ? ST_SHIFT : ST_LOOP;
          end
        end
        ST_IINIT: begin
          r0_q    <= pr_q;
          r1_q    <= g_q;
          t0_q    <= '0;
          t1_q    <= (pr_q == W'(1)) ? '0 : W'(1);
          state_q <= ST_ITEST;
        end
        ST_ITEST: begin
          state_q <= (r1_q == '0) ? ST_SLOPE : ST_IDIV;
        end
        ST_IQR: begin
          if (q_q >= pr_q) begin
            q_q <= q_q - pr_q;
          end
          state_q <= ST_IMUL;
        end
        ST_WB: begin
          if (dst_q) begin
            ax_q    <= e_q;
            ay_q    <= g_q;
            state_q <= ST_SHIFT;
          end else begin
            dx_q    <= e_q;
            dy_q    <= g_q;
            state_q <= ST_LOOP;
          end
        end
        ST_OUT: begin
          if (!ovalid_q || result_o.ready) begin
            rx_q     <= ax_q;
            ry_q     <= ay_q;
            ovalid_q <= 1'b1;
            state_q  <= ST_IDLE;
          end
        end
        default: begin
          if (pend_q && fau_done) begin
            case (state_q)
              ST_RX:    begin dx_q <= fau_rem; state_q <= ST_RY; end
              ST_RY:    begin dy_q <= fau_rem; state_q <= ST_RA; end
              ST_RA: begin
                ar_q    <= fau_rem;
                ax_q    <= dx_q;
                ay_q    <= dy_q;
                k_q     <= (k_q == '0) ? '0 : k_q - 1'b1;
                state_q <= ST_LOOP;
              end
              ST_PDX:   begin e_q <= fau_y; state_q <= ST_PDY; end
              ST_PDY:   begin f_q <= fau_y; state_q <= ST_PCHK; end
              ST_PG:    begin g_q <= fau_y; state_q <= ST_TSQ; end
              ST_TSQ:   begin s_q <= fau_y; state_q <= ST_T2; end
              ST_T2:    begin f_q <= fau_y; state_q <= ST_T3; end
              ST_T3:    begin f_q <= fau_y; state_q <= ST_TA; end
              ST_TA:    begin f_q <= fau_y; state_q <= ST_IINIT; end
              ST_IDIV: begin
                q_q     <= fau_y;
                r0_q    <= r1_q;
                r1_q    <= fau_rem;
                state_q <= ST_IQR;
              end
              ST_IMUL:  begin q_q <= fau_y; state_q <= ST_ISUB; end
              ST_ISUB: begin
                t1_q    <= fau_y;
                t0_q    <= t1_q;
                state_q <= ST_ITEST;
              end
              ST_SLOPE: begin s_q <= fau_y; state_q <= ST_X1; end
              ST_X1:    begin g_q <= fau_y; state_q <= ST_X2; end
              ST_X2:    begin g_q <= fau_y; state_q <= ST_X3; end
              ST_X3:    begin e_q <= fau_y; state_q <= ST_Y1; end
              ST_Y1:    begin g_q <= fau_y; state_q <= ST_Y2; end
              ST_Y2:    begin g_q <= fau_y; state_q <= ST_Y3; end
              ST_Y3:    begin g_q <= fau_y; state_q <= ST_WB; end
              default:  begin state_q <= ST_IDLE; end
            endcase
          end
        end
      endcase
    end
  end

  assign point_i.ready   = (state_q == ST_IDLE);
  assign result_o.valid  = ovalid_q;
  assign result_o.result_x = rx_q;
  assign result_o.result_y = ry_q;

  `ECCPSM_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, point_i.valid && point_i.ready, !point_i.ready, "request taken while another is in work")
  `ECCPSM_ASSERT_NOW(a_done_pending, clk_i, rst_ni, fau_done, pend_q, "arithmetic result without an outstanding operation")
  `ECCPSM_ASSERT_NOW(a_out_load, clk_i, rst_ni, $rose(ovalid_q), $past(state_q == ST_OUT), "result register loaded outside the output state")

endmodule
`default_nettype wire

[rtl/core/eccpsm_fau.sv]
// Field arithmetic unit: modular add and subtract, bit-serial modular multiply
// and bit-serial restoring division. Depends on eccpsm_pkg.
`default_nettype none
module eccpsm_fau #(
  parameter int unsigned W = eccpsm_pkg::DEFAULT_FIELD_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  eccpsm_pkg::fau_req_t  req_i,
  input  logic [W-1:0]          a_i,
  input  logic [W-1:0]          b_i,
  input  logic [W-1:0]          p_i,
  output logic                  done_o,
  output logic [W-1:0]          y_o,
  output logic [W-1:0]          rem_o
);
  import eccpsm_pkg::*;

  localparam int unsigned CW = $clog2(W);

  logic          busy_q;
  logic          ph_q;
  logic [CW-1:0] cnt_q;
  fau_op_e       op_q;
  logic [W-1:0]  acc_q;
  logic [W-1:0]  aux_q;
  logic [W-1:0]  opa_q;
  logic          done_q;

  logic [W:0]   dbl, dbl_r, sum, sum_r, trial, trial_r, s0, s0_r;
  logic         trial_ge;
  logic [W-1:0] diff;

  always_comb begin
    dbl      = {acc_q, 1'b0};
    dbl_r    = (dbl >= {1'b0, p_i}) ? dbl - {1'b0, p_i} : dbl;
    sum      = {1'b0, acc_q} + {1'b0, opa_q};
    sum_r    = (sum >= {1'b0, p_i}) ? sum - {1'b0, p_i} : sum;
    trial    = {acc_q, aux_q[W-1]};
    trial_ge = (trial >= {1'b0, opa_q});
    trial_r  = trial_ge ? trial - {1'b0, opa_q} : trial;
    s0       = {1'b0, a_i} + {1'b0, b_i};
    s0_r     = (s0 >= {1'b0, p_i}) ? s0 - {1'b0, p_i} : s0;
    diff     = (a_i >= b_i) ? a_i - b_i : a_i - b_i + p_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ph_q   <= 1'b0;
      cnt_q  <= '0;
      op_q   <= FAU_ADD;
      acc_q  <= '0;
      aux_q  <= '0;
      opa_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        op_q <= req_i.op;
        case (req_i.op)
          FAU_ADD: begin
            acc_q  <= s0_r[W-1:0];
            done_q <= 1'b1;
          end
          FAU_SUB: begin
            acc_q  <= diff;
            done_q <= 1'b1;
          end
          FAU_MUL: begin
            acc_q  <= '0;
            opa_q  <= a_i;
            aux_q  <= b_i;
            ph_q   <= 1'b0;
            cnt_q  <= CW'(W - 1);
            busy_q <= 1'b1;
          end
          FAU_DIV: begin
            acc_q  <= '0;
            opa_q  <= b_i;
            aux_q  <= a_i;
            ph_q   <= 1'b0;
            cnt_q  <= CW'(W - 1);
            busy_q <= 1'b1;
          end
          default: begin
            done_q <= 1'b1;
          end
        endcase
      end else if (busy_q) begin
        if (op_q == FAU_MUL) begin
          if (!ph_q) begin
            acc_q <= dbl_r[W-1:0];
            ph_q  <= 1'b1;
          end else begin
            if (aux_q[W-1]) begin
              acc_q <= sum_r[W-1:0];
            end
            aux_q <= {aux_q[W-2:0], 1'b0};
            ph_q  <= 1'b0;
            if (cnt_q == '0) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end else begin
              cnt_q <= cnt_q - 1'b1;
            end
          end
        end else begin
          acc_q <= trial_r[W-1:0];
          aux_q <= {aux_q[W-2:0], trial_ge};
          if (cnt_q == '0) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
      end
    end
  end

  assign done_o = done_q;
  assign y_o    = (op_q == FAU_DIV) ? aux_q : acc_q;
  assign rem_o  = acc_q;

endmodule
`default_nettype wire

[sim/tb_top.sv]
// Testbench of the elliptic curve point multiplier: directed and random
// requests checked against a predictor of k times the point modulo p.
// Depends on eccpsm_pkg, the request channel interfaces and the top level.
`default_nettype none
module tb_top;
  import eccpsm_pkg::*;

  typedef logic [63:0] field_t;
  typedef struct packed {
    field_t x;
    field_t y;
  } point_t;

  localparam field_t BIG_PRIME = 64'hFFFF_FFFF_FFFF_FFC5;
  localparam field_t ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  eccpsm_in_if point_ch ();
  eccpsm_out_if result_ch ();

  ecc_point_scalar_multiply dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .point_i  (point_ch.sink),
    .result_o (result_ch.source)
  );

  field_t modulus_cfg;
  field_t coeff_a_cfg;
  point_t product_q[$];
  int unsigned mismatches;
  bit idle_en;
  int unsigned hold_cycles;
  int unsigned stall_left;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #200_000_000;
    $display("ecc_point_scalar_multiply verification failed");
    $finish;
  end

  function automatic field_t f_add(field_t a, field_t b, field_t p);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, p}) begin
      s = s - {1'b0, p};
    end
    return s[63:0];
  endfunction

  function automatic field_t f_sub(field_t a, field_t b, field_t p);
    return (a >= b) ? a - b : a + (p - b);
  endfunction

  function automatic field_t f_mul(field_t a, field_t b, field_t p);
    logic [127:0] prod;
    prod = {64'd0, a % p} * {64'd0, b % p};
    return field_t'(prod % {64'd0, p});
  endfunction

  function automatic field_t f_inv(field_t v, field_t p);
    field_t r0, r1, t0, t1, q, nr, nt;
    r0 = p;
    r1 = v % p;
    t0 = '0;
    t1 = 64'd1 % p;
    while (r1 != 0) begin
      q = r0 / r1;
      nr = r0 - q * r1;
      nt = f_sub(t0, f_mul(q % p, t1, p), p);
      r0 = r1;
      r1 = nr;
      t0 = t1;
      t1 = nt;
    end
    return t0;
  endfunction

  // Sum of two points; with equal x and unequal y the second one is returned.
  function automatic point_t point_sum(point_t pp, point_t qq, field_t a, field_t p);
    field_t dx, dy, inv, s, t, nx;
    point_t r;
    dx = f_sub(qq.x, pp.x, p);
    dy = f_sub(qq.y, pp.y, p);
    if (dx != 0) begin
      s = f_mul(dy, f_inv(dx, p), p);
    end else if (dy == 0) begin
      inv = f_inv(f_add(pp.y, qq.y, p), p);
      t = f_add(f_mul(64'd3 % p, f_mul(pp.x, pp.x, p), p), a, p);
      s = f_mul(t, inv, p);
    end else begin
      return qq;
    end
    t = f_sub(f_mul(s, s, p), pp.x, p);
    nx = f_sub(t, qq.x, p);
    r.x = nx;
    r.y = f_sub(f_mul(f_sub(pp.x, nx, p), s, p), pp.y, p);
    return r;
  endfunction

  function automatic point_t scalar_product(field_t x, field_t y, field_t k);
    point_t acc, dbl;
    field_t a, p, rest;
    p = modulus_cfg;
    if (p == 0) begin
      return '0;
    end
    a = coeff_a_cfg % p;
    dbl.x = x % p;
    dbl.y = y % p;
    acc = dbl;
    rest = (k == 0) ? '0 : k - 1;
    while (rest != 0) begin
      if (rest[0]) begin
        acc = point_sum(dbl, acc, a, p);
      end
      rest = rest >> 1;
      if (rest != 0) begin
        dbl = point_sum(dbl, dbl, a, p);
      end
    end
    return acc;
  endfunction

  // Result side: random stalls, long hold-offs, and the comparison.
  always @(posedge clk_i) begin
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (product_q.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h", $time, result_ch.result_x,
                 result_ch.result_y);
        mismatches++;
      end else begin
        if (result_ch.result_x !== product_q[0].x) begin
          $display("%0t: result_x expected %h actual %h", $time, product_q[0].x,
                   result_ch.result_x);
          mismatches++;
        end
        if (result_ch.result_y !== product_q[0].y) begin
          $display("%0t: result_y expected %h actual %h", $time, product_q[0].y,
                   result_ch.result_y);
          mismatches++;
        end
        void'(product_q.pop_front());
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      result_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  task automatic write_reg(logic idx, field_t value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(idx) << 3;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_PRIME) begin
      modulus_cfg = value;
    end else begin
      coeff_a_cfg = value;
    end
  endtask

  task automatic send_point(field_t x, field_t y, field_t k);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      point_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    point_ch.point_x <= x;
    point_ch.point_y <= y;
    point_ch.scalar <= k;
    point_ch.valid <= 1'b1;
    @(posedge clk_i);
    while (!point_ch.ready) @(posedge clk_i);
    product_q.push_back(scalar_product(x, y, k));
  endtask

  task automatic drain();
    point_ch.valid <= 1'b0;
    while (product_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic field_t rand_field();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_reset_values();
    send_point(64'd3, 64'd7, 64'd0);
    send_point(64'd3, 64'd7, 64'd1);
    send_point(64'd3, 64'd7, 64'd2);
    send_point(64'd5, 64'd0, 64'd2);
    send_point(64'd5, 64'd0, 64'd3);
    send_point(ALL_ONES, ALL_ONES, 64'd5);
    send_point(64'd0, 64'd0, 64'd9);
    drain();
  endtask

  task automatic test_modulus_corners();
    write_reg(REG_PRIME, 64'd0);
    send_point(64'd9, 64'd4, 64'd6);
    drain();
    write_reg(REG_PRIME, 64'd1);
    send_point(64'd9, 64'd4, 64'd6);
    drain();
    write_reg(REG_PRIME, 64'd15);
    write_reg(REG_CURVE_A, ALL_ONES);
    send_point(64'd4, 64'd6, 64'd7);
    send_point(64'd10, 64'd3, 64'd4);
    drain();
    write_reg(REG_PRIME, BIG_PRIME);
    write_reg(REG_CURVE_A, 64'd0);
    send_point(ALL_ONES, 64'h1234_5678_9ABC_DEF0, 64'd2);
    send_point(64'h8000_0000_0000_0001, 64'd77, 64'd3);
    drain();
  endtask

  task automatic test_long_scalars();
    write_reg(REG_PRIME, 64'd3);
    write_reg(REG_CURVE_A, 64'd2);
    send_point(64'd1, 64'd2, ALL_ONES);
    repeat (3) send_point(rand_field(), rand_field(), rand_field());
    drain();
  endtask

  task automatic test_output_backpressure();
    write_reg(REG_PRIME, 64'd7);
    write_reg(REG_CURVE_A, 64'd3);
    hold_cycles = 60000;
    repeat (5) send_point(rand_field(), rand_field(), field_t'($urandom_range(0, 3)));
    drain();
  endtask

  task automatic test_random_points();
    field_t primes[10] = '{64'd3, 64'd5, 64'd7, 64'd11, 64'd13, 64'd31, 64'd61,
                           64'd127, 64'd251, 64'd65521};
    field_t p;
    for (int phase = 0; phase < 8; phase++) begin
      p = primes[$urandom_range(0, 9)];
      write_reg(REG_PRIME, p);
      write_reg(REG_CURVE_A, ($urandom_range(0, 3) == 0) ? rand_field()
                                                          : field_t'($urandom()) % p);
      if (phase == 6) begin
        idle_en = 1'b0;
      end
      repeat (10) begin
        if ($urandom_range(0, 2) == 0) begin
          send_point(rand_field(), rand_field(), field_t'($urandom_range(0, 7)));
        end else begin
          send_point(field_t'($urandom()) % p, field_t'($urandom()) % p,
                     field_t'($urandom_range(0, 7)));
        end
      end
      drain();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    point_ch.valid = 1'b0;
    point_ch.point_x = '0;
    point_ch.point_y = '0;
    point_ch.scalar = '0;
    result_ch.ready = 1'b0;
    modulus_cfg = PRIME_RESET;
    coeff_a_cfg = CURVE_A_RESET;
    mismatches = 0;
    idle_en = 1'b1;
    hold_cycles = 0;
    stall_left = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_modulus_corners();
    test_long_scalars();
    test_output_backpressure();
    test_random_points();
    if (mismatches == 0) begin
      $display("ecc_point_scalar_multiply verification clean");
    end else begin
      $display("ecc_point_scalar_multiply verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
